/* rtl/core/pidaw_pkg.sv */
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, word types and register indexes of the anti-windup PID.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   localparam int SAMPLE_W = 16;   // Q.8 samples
   localparam int DT_W     = 16;   // Q0.16 seconds
   localparam int GAIN_W   = 16;   // Q4.12 gains
   localparam int ACC_W    = 32;   // Q.16 integral
   localparam int WL_W     = 31;
   localparam int MX_W     = 23;
   localparam int DRIVE_W  = 24;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam int ERR_W  = SAMPLE_W + 1;
   // multiplier: narrow signed side and wide signed side
   localparam int MUL_A_W = ERR_W;
   localparam int MUL_B_W = ACC_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   // integral candidate before the windup clamp
   localparam int CAND_W = ACC_W + 2;
   // Q.28 output sum, and Q.8 value after the shift by 20
   localparam int SUM_W  = ACC_W + GAIN_W + 2;
   localparam int FRAC_SHIFT = 20;
   localparam int OUTV_W = SUM_W - FRAC_SHIFT;

   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDUP_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_OUTPUT   = 3'd4;

   localparam logic [GAIN_W-1:0] KP_RESET = 16'd4915;
   localparam logic [GAIN_W-1:0] KI_RESET = 16'd819;
   localparam logic [GAIN_W-1:0] KD_RESET = 16'd1229;
   localparam logic [WL_W-1:0]   WL_RESET = 31'd6553600;
   localparam logic [MX_W-1:0]   MX_RESET = 23'd51200;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] setpoint;
      logic signed [SAMPLE_W-1:0] measured;
      logic signed [SAMPLE_W-1:0] rate;
      logic        [DT_W-1:0]     time_step;
   } req_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      clamped;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [GAIN_W-1:0] kd_gain;
      logic [WL_W-1:0]   windup_limit;
      logic [MX_W-1:0]   max_output;
   } cfg_type;

endpackage

/* rtl/core/pidaw_csr.sv */
// ----------------------------------------------------------------------------
// pidaw_csr
// Gain and limit registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module pidaw_csr
   import pidaw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KP_GAIN:      cfg_in.kp_gain      = csr_wdata[GAIN_W-1:0];
            CSR_KI_GAIN:      cfg_in.ki_gain      = csr_wdata[GAIN_W-1:0];
            CSR_KD_GAIN:      cfg_in.kd_gain      = csr_wdata[GAIN_W-1:0];
            CSR_WINDUP_LIMIT: cfg_in.windup_limit = csr_wdata[WL_W-1:0];
            CSR_MAX_OUTPUT:   cfg_in.max_output   = csr_wdata[MX_W-1:0];
            default:          cfg_in = cfg_ff;   // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain      <= KP_RESET;
         cfg_ff.ki_gain      <= KI_RESET;
         cfg_ff.kd_gain      <= KD_RESET;
         cfg_ff.windup_limit <= WL_RESET;
         cfg_ff.max_output   <= MX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/pidaw_mul.sv */
// ----------------------------------------------------------------------------
// pidaw_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidaw_mul
   import pidaw_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign prod = prod_ff;

endmodule

/* rtl/core/pid_antiwindup_controller.sv */
// ----------------------------------------------------------------------------
// pid_antiwindup_controller
// Fixed-point PID with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : valid/ready channel, one word = setpoint, measured, rate,
//           time_step. req_ready is high only while the sequencer is idle.
//   rsp_* : valid/ready channel, one word = drive, clamped per request.
//   csr_* : write-only gain/limit registers; write while the block is idle.
// Timing:
//   One shared 17x32 multiplier runs four products in sequence (err*dt,
//   kp*err, ki*candidate, kd*rate), stepping through MDT, CAND, MKI, MKD,
//   SUB and FIN; the response is registered in FIN, then back to IDLE.
//   A zero time_step skips the arithmetic and goes straight to FIN: drive 0.
//   The response sits in an output register, so a new request is taken
//   while it waits; if rsp_ready stays low, the next result holds in the
//   final step until the output register frees up.
// Reset:
//   Synchronous, active high. Gains and limits return to defaults, the
//   integral clears and the first-step flag is set, so the first request
//   with a nonzero time_step starts from an empty integral.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller
   import pidaw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MDT,
      S_CAND,
      S_MKI,
      S_MKD,
      S_SUB,
      S_FIN
   } state_type;

   cfg_type cfg;

   state_type                 state_ff, state_in;
   logic                      zero_ff, zero_in;
   logic                      first_ff, first_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [SAMPLE_W-1:0] rate_ff, rate_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic signed [ACC_W-1:0]   cand_ff, cand_in;
   logic signed [ACC_W-1:0]   integ_ff, integ_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic signed [ACC_W-1:0]   integ_eff;
   logic signed [CAND_W-1:0]  cand_sum;
   logic signed [CAND_W-1:0]  wl_s;
   logic signed [SUM_W-1:0]   prod_q28;
   logic signed [SUM_W-1:0]   prod_full;
   logic signed [OUTV_W-1:0]  outv;
   logic signed [OUTV_W-1:0]  mx_s;
   logic signed [OUTV_W-1:0]  lim;
   logic                      over, under, keep;
   logic                      out_free;

   pidaw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidaw_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // operand select for the shared multiplier; product shows up next state
   always_comb begin
      case (state_ff)
         S_MDT: begin
            mul_a = err_ff;
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
         S_CAND: begin
            mul_a = err_ff;
            mul_b = MUL_B_W'($signed({1'b0, cfg.kp_gain}));
         end
         S_MKI: begin
            mul_a = MUL_A_W'($signed({1'b0, cfg.ki_gain}));
            mul_b = cand_ff;
         end
         S_MKD: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = MUL_B_W'($signed({1'b0, cfg.kd_gain}));
         end
         default: begin
            mul_a = err_ff;
            mul_b = MUL_B_W'($signed({1'b0, dt_ff}));
         end
      endcase
   end

   // integral candidate: err*dt is Q.24, shift to Q.16 (floor), clamp
   assign integ_eff = first_ff ? '0 : integ_ff;
   assign cand_sum  = CAND_W'(integ_eff) + $signed(prod[8 +: CAND_W]);
   assign wl_s      = CAND_W'($signed({1'b0, cfg.windup_limit}));

   // Q.20 products scaled to Q.28; ki*cand is already Q.28
   assign prod_q28  = SUM_W'($signed({prod[PROD_W-9:0], 8'b0}));
   assign prod_full = SUM_W'(prod);

   // Q.28 sum to Q.8 (floor), then output clamp
   assign outv  = sum_ff[SUM_W-1:FRAC_SHIFT];
   assign mx_s  = OUTV_W'($signed({1'b0, cfg.max_output}));
   assign over  = outv > mx_s;
   assign under = outv < -mx_s;
   assign lim   = over ? mx_s : (under ? -mx_s : outv);
   // keep the candidate unless saturated with the error pushing further out
   assign keep  = !(over || under) || (over && err_ff < 0) || (under && err_ff > 0);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      zero_in      = zero_ff;
      first_in     = first_ff;
      err_in       = err_ff;
      rate_in      = rate_ff;
      dt_in        = dt_ff;
      cand_in      = cand_ff;
      integ_in     = integ_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in  = ERR_W'(req_data.setpoint) - ERR_W'(req_data.measured);
               rate_in = req_data.rate;
               dt_in   = req_data.time_step;
               zero_in = (req_data.time_step == '0);
               state_in = (req_data.time_step == '0) ? S_FIN : S_MDT;
            end
         end
         S_MDT: begin
            state_in = S_CAND;
         end
         S_CAND: begin
            if (cand_sum > wl_s) begin
               cand_in = wl_s[ACC_W-1:0];
            end else if (cand_sum < -wl_s) begin
               cand_in = ACC_W'(-wl_s);
            end else begin
               cand_in = cand_sum[ACC_W-1:0];
            end
            state_in = S_MKI;
         end
         S_MKI: begin
            sum_in   = prod_q28;            // kp*err
            state_in = S_MKD;
         end
         S_MKD: begin
            sum_in   = sum_ff + prod_full;  // + ki*cand
            state_in = S_SUB;
         end
         S_SUB: begin
            sum_in   = sum_ff - prod_q28;   // - kd*rate
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  rsp_in.drive   = '0;
                  rsp_in.clamped = 1'b0;
               end else begin
                  rsp_in.drive   = lim[DRIVE_W-1:0];
                  rsp_in.clamped = over || under;
                  integ_in       = keep ? cand_ff : integ_eff;
                  first_in       = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b1;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      err_ff  <= err_in;
      rate_ff <= rate_in;
      dt_ff   <= dt_in;
      cand_ff <= cand_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* verif/pid_antiwindup_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_tb
// Self-checking bench for the fixed-point PID with conditional integration.
// A predictor tracks gains, limits, the Q.16 integral and the first-step
// flag, and works out drive and clamp for every accepted request word.
// Directed edge cases run first, then closed-loop style random traffic
// under several register settings and three handshake idling patterns.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller_tb;
   import pidaw_pkg::*;

   localparam int  SETTLE_CYCLES  = 12;
   localparam int  WATCHDOG_LIMIT = 2000;
   localparam int  SAMPLE_MAX     = 32767;
   localparam int  SAMPLE_MIN     = -32768;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [GAIN_W-1:0] kp_set = KP_RESET;
   logic [GAIN_W-1:0] ki_set = KI_RESET;
   logic [GAIN_W-1:0] kd_set = KD_RESET;
   logic [WL_W-1:0]   wl_set = WL_RESET;
   logic [MX_W-1:0]   mx_set = MX_RESET;
   longint            integral_q16  = 0;
   bit                first_pending = 1'b1;

   rsp_type drive_q[$];
   int      fail_count  = 0;
   int      rsp_count   = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 0;
   int      rsp_idle_pct  = 0;
   int      aim_pos  = 0;
   int      meas_pos = 0;

   pid_antiwindup_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic longint clip(input longint x, input longint lo, input longint hi);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   function automatic rsp_type pid_step(input req_type w);
      longint  err, dt, rt, cand, acc_sum, outv, lim, wl, mx, acc_hi;
      bit      sat;
      rsp_type r;
      r = '0;
      if (w.time_step == '0) return r;   // zero step: drive 0, state untouched
      if (first_pending) begin
         integral_q16  = 0;
         first_pending = 1'b0;
      end
      acc_hi = (longint'(1) <<< (ACC_W - 1)) - 1;
      wl   = longint'(wl_set);
      mx   = longint'(mx_set);
      dt   = longint'(w.time_step);
      rt   = longint'($signed(w.rate));
      err  = longint'($signed(w.setpoint)) - longint'($signed(w.measured));
      cand = integral_q16 + ((err * dt) >>> 8);
      cand = clip(cand, -wl, wl);
      cand = clip(cand, -acc_hi - 1, acc_hi);
      acc_sum = longint'(kp_set) * err * 256 + longint'(ki_set) * cand
              - longint'(kd_set) * rt * 256;
      outv = acc_sum >>> FRAC_SHIFT;
      lim  = clip(outv, -mx, mx);
      sat  = (outv != lim);
      // conditional integration: keep the candidate unless it deepens saturation
      if (!sat || (outv > mx && err < 0) || (outv < -mx && err > 0))
         integral_q16 = cand;
      r.drive   = lim[DRIVE_W-1:0];
      r.clamped = sat;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      drive_q.push_back(pid_step(w));
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_KP_GAIN:      kp_set = data[GAIN_W-1:0];
         CSR_KI_GAIN:      ki_set = data[GAIN_W-1:0];
         CSR_KD_GAIN:      kd_set = data[GAIN_W-1:0];
         CSR_WINDUP_LIMIT: wl_set = data[WL_W-1:0];
         CSR_MAX_OUTPUT:   mx_set = data[MX_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [WL_W-1:0] wl,
                              input logic [MX_W-1:0] mx);
      hold_until_drained();
      write_reg(CSR_KP_GAIN, CSR_DATA_W'(kp));
      write_reg(CSR_KI_GAIN, CSR_DATA_W'(ki));
      write_reg(CSR_KD_GAIN, CSR_DATA_W'(kd));
      write_reg(CSR_WINDUP_LIMIT, CSR_DATA_W'(wl));
      write_reg(CSR_MAX_OUTPUT, CSR_DATA_W'(mx));
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [SAMPLE_W-1:0] to_sample(input int v);
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic req_type make_word(input int sp, input int ms, input int rt, input int dt);
      req_type w;
      w.setpoint  = to_sample(sp);
      w.measured  = to_sample(ms);
      w.rate      = to_sample(rt);
      w.time_step = dt[DT_W-1:0];
      return w;
   endfunction

   // mostly a plant creeping toward a held target (with overshoot), plus noise
   function automatic req_type next_word();
      req_type     w;
      int          pick, stride;
      pick = $urandom_range(99);
      if (pick < 10) begin
         w = req_type'({$urandom, $urandom});
      end else if (pick < 16) begin
         w = req_type'({$urandom, $urandom});
         w.time_step = '0;
      end else if (pick < 20) begin
         w = make_word($urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN,
                       $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN,
                       $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN,
                       $urandom_range(1) ? 65535 : 1);
      end else begin
         if ($urandom_range(15) == 0)
            aim_pos = int'($signed(SAMPLE_W'($urandom)));
         stride = ((aim_pos - meas_pos) * int'($urandom_range(14, 1))) / 8
                + int'($urandom_range(64)) - 32;
         meas_pos = int'($signed(to_sample(meas_pos + stride)));
         w = make_word(aim_pos, meas_pos, stride * 4 + int'($urandom_range(256)) - 128,
                       ($urandom_range(9) == 0) ? int'($urandom_range(65535, 1))
                                                : int'($urandom_range(4096, 1)));
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_edge_cases();
      send_word(make_word(100, -100, 5, 0));              // zero step before any update
      send_word(make_word(SAMPLE_MAX, SAMPLE_MIN, 0, 65535));
      send_word(make_word(SAMPLE_MIN, SAMPLE_MAX, 0, 65535));
      send_word(make_word(0, 0, SAMPLE_MAX, 1));
      send_word(make_word(0, 0, SAMPLE_MIN, 1));
      send_word(make_word(SAMPLE_MAX, SAMPLE_MAX, 0, 65535));
      send_word(make_word(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 0));
      repeat (4) send_word(make_word(1000, 900, 16, 16384));
      repeat (3) send_word(make_word(900, 1000, -16, 16384));
      send_word(make_word(-1, 0, 0, 32768));
      repeat (3) send_word(make_word(20000, -20000, -300, 65535));   // wind into the limit
      repeat (2) send_word(make_word(-20000, 20000, 300, 65535));
      send_word(make_word(0, 0, 0, 0));
   endtask

   task automatic test_tracking(input int n_words, input bit pause_mid);
      for (int i = 0; i < n_words; i++) begin
         if (pause_mid && i == n_words / 2)
            hold_until_drained();
         send_word(next_word());
      end
   endtask

   task automatic test_unmapped_index();
      hold_until_drained();
      for (int k = 1; k <= 3; k++)
         write_reg(CSR_MAX_OUTPUT + CSR_IDX_W'(k), CSR_DATA_W'($urandom));
      test_tracking(20, 1'b0);
   endtask

   task automatic test_random_config(input int n_words);
      load_config(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  WL_W'($urandom), MX_W'($urandom));
      test_tracking(n_words, 1'b0);
   endtask

   task automatic test_tight_limits(input int n_words);
      // moderate gains with limits small enough to saturate often
      load_config(GAIN_W'($urandom_range(16384, 2048)), GAIN_W'($urandom_range(8192, 256)),
                  GAIN_W'($urandom_range(8192)), WL_W'($urandom_range(1 << 24, 1 << 12)),
                  MX_W'($urandom_range(40000, 256)));
      test_tracking(n_words, 1'b0);
   endtask

   task automatic test_extreme_config(input int n_words);
      load_config('1, '1, '1, '1, '1);
      test_tracking(n_words, 1'b0);
      load_config('0, '0, '0, '0, '0);
      test_tracking(n_words / 2, 1'b0);
      load_config(GAIN_W'($urandom), '1, GAIN_W'($urandom), '0, '1);   // integral pinned at zero
      test_tracking(n_words / 2, 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("MISMATCH at response %0d: %s expected %0d got %0d", rsp_count, what, want, got);
      fail_count++;
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         rsp_type want;
         if (drive_q.size() == 0) begin
            report_mismatch("unexpected word, drive", 0, longint'($signed(rsp_data.drive)));
         end else begin
            want = drive_q.pop_front();
            if (rsp_data.drive !== want.drive)
               report_mismatch("drive", longint'($signed(want.drive)),
                               longint'($signed(rsp_data.drive)));
            if (rsp_data.clamped !== want.clamped)
               report_mismatch("clamped", longint'(want.clamped), longint'(rsp_data.clamped));
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_edge_cases();

      send_idle_pct = 35;
      rsp_idle_pct  = 66;
      test_tracking(120, 1'b0);
      test_unmapped_index();
      test_tight_limits(100);

      send_idle_pct = 66;
      rsp_idle_pct  = 35;
      test_extreme_config(80);
      test_random_config(80);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_tight_limits(60);
      test_tracking(60, 1'b1);

      hold_until_drained();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
